FILE: hw/rtl/pfm_pkg.sv
// ----------------------------------------------------------------------------
// Power fault monitor package
// Shared types, register indexes, message codes and field widths.
// ----------------------------------------------------------------------------
package pfm_pkg;

  localparam int TEMP_SHIFT_DEF = 7;
  localparam int TICK_WIDTH_DEF = 32;

  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 56;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int NUM_FAULTS = 9;

  // Fault positions in test order.
  localparam int F_CUR = 6;
  localparam int F_AIR = 7;
  localparam int F_FET = 8;

  typedef enum logic [1:0] {
    PM_NC  = 2'd0,
    PM_OFF = 2'd1,
    PM_ON  = 2'd2
  } power_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CURRENT_LIMIT = 3'd0,
    REG_AIR_LIMIT     = 3'd1,
    REG_FET_LIMIT     = 3'd2,
    REG_DISABLE_MASK  = 3'd3,
    REG_HOLDOFF       = 3'd4
  } reg_index_t;

  typedef enum logic [1:0] {
    CS_CHANGED = 2'd0,
    CS_ALREADY = 2'd1,
    CS_INVALID = 2'd2
  } change_status_t;

  typedef enum logic [1:0] {
    LED_NONE  = 2'd0,
    LED_TEMP  = 2'd1,
    LED_OTHER = 2'd2
  } led_kind_t;

  localparam logic OP_CHECK   = 1'b0;
  localparam logic OP_REQUEST = 1'b1;
  localparam logic KIND_ALARM = 1'b0;
  localparam logic KIND_REPLY = 1'b1;

  localparam logic [7:0] MSG_FET     = 8'hB1;
  localparam logic [7:0] MSG_AIR     = 8'hB2;
  localparam logic [7:0] MSG_CURRENT = 8'hB5;
  localparam logic [7:0] MSG_PWM0    = 8'hB9;
  localparam logic [7:0] MSG_PWM12   = 8'hBA;
  localparam logic [7:0] MSG_PWM345  = 8'hBB;

  typedef struct packed {
    logic               op;
    logic [31:0]        now_tick;
    logic [5:0]         pwm_status;
    logic signed [15:0] mean_current;
    logic signed [15:0] volt_at_peak;
    logic [15:0]        air_temp_raw;
    logic [15:0]        fet_temp_raw;
    logic [1:0]         requested_state;
  } item_t;

  typedef struct packed {
    logic signed [15:0] current_limit;
    logic [8:0]         air_temp_limit;
    logic [8:0]         fet_temp_limit;
    logic [13:0]        alert_disable_mask;
    logic [31:0]        holdoff_ticks;
  } cfg_t;

  // One evaluated item handed to the result sequencer.
  typedef struct packed {
    logic                  is_reply;
    power_mode_t           reply_state;
    logic                  reply_down;
    logic                  reply_keepalive;
    change_status_t        reply_status;
    logic [NUM_FAULTS-1:0] alarms;
    logic signed [15:0]    mean_current;
    logic signed [15:0]    volt_at_peak;
    logic [7:0]            air_byte;
    logic [7:0]            fet_byte;
  } job_t;

  function automatic logic [7:0] pwm_code(input logic [3:0] idx);
    logic [7:0] code;
    case (idx)
      4'd0:          code = MSG_PWM0;
      4'd1, 4'd2:    code = MSG_PWM12;
      default:       code = MSG_PWM345;
    endcase
    return code;
  endfunction

  function automatic logic [7:0] pwm_arg(input logic [3:0] idx);
    logic [7:0] arg;
    case (idx)
      4'd1, 4'd3: arg = 8'h0A;
      4'd2, 4'd4: arg = 8'h0B;
      4'd5:       arg = 8'h0C;
      default:    arg = 8'h00;
    endcase
    return arg;
  endfunction

endpackage

FILE: hw/rtl/pfm_eval.sv
// ----------------------------------------------------------------------------
// Power fault monitor evaluation stage
// Holds power state and holdoff deadline; turns one item into a job.
// ----------------------------------------------------------------------------
module pfm_eval #(
  parameter int TEMP_SHIFT = pfm_pkg::TEMP_SHIFT_DEF,
  parameter int TICK_WIDTH = pfm_pkg::TICK_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  pfm_pkg::item_t in_item,
  input  pfm_pkg::cfg_t  cfg,
  input  logic           load_ok,
  output logic           consume,
  output logic           job_load,
  output pfm_pkg::job_t  job
);
  import pfm_pkg::*;

  power_mode_t           power_mode;
  logic [TICK_WIDTH-1:0] deadline;

  logic [TICK_WIDTH+31:0] now_wide;
  logic [TICK_WIDTH+31:0] hold_wide;
  logic [TICK_WIDTH-1:0]  now_t;
  logic [TICK_WIDTH-1:0]  deadline_next;
  logic [15:0]            air_t;
  logic [15:0]            fet_t;
  logic                   active;
  logic [NUM_FAULTS-1:0]  faults;
  logic [NUM_FAULTS-1:0]  disabled;
  logic [NUM_FAULTS-1:0]  unmasked;
  logic                   has_results;
  logic                   req_invalid;
  logic                   req_same;

  // The tick is taken modulo 2^TICK_WIDTH, zero-extended when wider.
  assign now_wide  = {{TICK_WIDTH{1'b0}}, in_item.now_tick};
  assign hold_wide = {{TICK_WIDTH{1'b0}}, cfg.holdoff_ticks};
  assign now_t     = now_wide[TICK_WIDTH-1:0];
  assign deadline_next = now_t + hold_wide[TICK_WIDTH-1:0];

  assign air_t = in_item.air_temp_raw >> TEMP_SHIFT;
  assign fet_t = in_item.fet_temp_raw >> TEMP_SHIFT;

  assign active = (in_item.op == OP_CHECK) && (deadline <= now_t) && (power_mode == PM_ON);

  assign faults[5:0]   = ~in_item.pwm_status;
  assign faults[F_CUR] = in_item.mean_current >= cfg.current_limit;
  assign faults[F_AIR] = air_t >= {7'd0, cfg.air_temp_limit};
  assign faults[F_FET] = fet_t >= {7'd0, cfg.fet_temp_limit};

  assign disabled = {cfg.alert_disable_mask[11], cfg.alert_disable_mask[10],
                     cfg.alert_disable_mask[9], cfg.alert_disable_mask[13],
                     cfg.alert_disable_mask[8:4]};
  assign unmasked = active ? (faults & ~disabled) : '0;

  assign has_results = (in_item.op == OP_REQUEST) || (unmasked != '0);
  assign consume     = in_valid && (!has_results || load_ok);
  assign job_load    = consume && has_results;

  assign req_invalid = (in_item.requested_state == 2'd3) ||
                       ((power_mode == PM_NC) && (in_item.requested_state == PM_ON));
  assign req_same    = in_item.requested_state == power_mode;

  always_comb begin
    job                 = '0;
    job.is_reply        = in_item.op;
    job.reply_state     = power_mode;
    job.reply_status    = CS_CHANGED;
    job.alarms          = unmasked;
    job.mean_current    = in_item.mean_current;
    job.volt_at_peak    = in_item.volt_at_peak;
    job.air_byte        = air_t[7:0];
    job.fet_byte        = fet_t[7:0];
    if (req_invalid) begin
      job.reply_status = CS_INVALID;
    end else if (req_same) begin
      job.reply_status = CS_ALREADY;
    end else begin
      job.reply_state     = power_mode_t'(in_item.requested_state);
      job.reply_down      = power_mode == PM_ON;
      job.reply_keepalive = (power_mode == PM_OFF) && (in_item.requested_state == PM_ON);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      power_mode <= PM_NC;
      deadline   <= '0;
    end else if (consume) begin
      if (in_item.op == OP_REQUEST) begin
        power_mode <= job.reply_state;
      end else if (active && faults != '0) begin
        deadline <= deadline_next;
        if (unmasked != '0) begin
          power_mode <= PM_OFF;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/pfm_emit.sv
// ----------------------------------------------------------------------------
// Power fault monitor result sequencer
// Holds one job and sends its alarm messages or reply one per transfer.
// ----------------------------------------------------------------------------
module pfm_emit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            job_load,
  input  pfm_pkg::job_t                   job_in,
  output logic                            load_ok,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [pfm_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                            m_tuser,
  output logic                            m_tlast
);
  import pfm_pkg::*;

  job_t                  job;
  logic                  job_valid;
  logic                  first;
  logic [3:0]            idx;
  logic [NUM_FAULTS-1:0] rest;
  logic                  last_now;
  logic [7:0]            msg_code;
  logic [15:0]           arg_a;
  logic [15:0]           arg_b;
  logic                  msg_long;
  power_mode_t           ps;
  logic                  pd;
  logic                  ka;
  change_status_t        cs;
  led_kind_t             led;

  assign rest     = job.alarms & (job.alarms - 1'b1);
  assign last_now = job.is_reply || (rest == '0);
  assign load_ok  = !job_valid || (m_tready && last_now);

  // Lowest pending alarm goes out first.
  always_comb begin
    idx = 4'd0;
    for (int i = NUM_FAULTS - 1; i >= 0; i--) begin
      if (job.alarms[i]) begin
        idx = 4'(i);
      end
    end
  end

  always_comb begin
    msg_code = '0;
    arg_a    = '0;
    arg_b    = '0;
    msg_long = 1'b0;
    ps       = job.reply_state;
    pd       = job.reply_down;
    ka       = job.reply_keepalive;
    cs       = job.reply_status;
    led      = LED_NONE;
    if (!job.is_reply) begin
      // A check only runs while on, so the first alarm trips on to off.
      ps  = PM_OFF;
      pd  = first;
      ka  = 1'b0;
      cs  = first ? CS_CHANGED : CS_ALREADY;
      led = LED_OTHER;
      case (idx)
        4'(F_CUR): begin
          msg_code = MSG_CURRENT;
          arg_a    = job.mean_current[15] ? 16'd0 : job.mean_current;
          arg_b    = job.volt_at_peak[15] ? 16'd0 : job.volt_at_peak;
          msg_long = 1'b1;
        end
        4'(F_AIR): begin
          msg_code = MSG_AIR;
          arg_a    = {job.air_byte, 8'd0};
          led      = LED_TEMP;
        end
        4'(F_FET): begin
          msg_code = MSG_FET;
          arg_a    = {job.fet_byte, 8'd0};
          led      = LED_TEMP;
        end
        default: begin
          msg_code = pwm_code(idx);
          arg_a    = {pwm_arg(idx), 8'd0};
        end
      endcase
    end
  end

  assign m_tvalid = job_valid;
  assign m_tuser  = job.is_reply ? KIND_REPLY : KIND_ALARM;
  assign m_tlast  = last_now;
  assign m_tdata  = {7'd0, led, cs, ka, pd, ps, msg_long, arg_b, arg_a, msg_code};

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (job_load) begin
      job_valid <= 1'b1;
    end else if (m_tready && last_now) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) begin
      job   <= job_in;
      first <= 1'b1;
    end else if (job_valid && m_tready) begin
      job.alarms <= rest;
      first      <= 1'b0;
    end
  end

endmodule

FILE: hw/rtl/power_fault_monitor.sv
// ----------------------------------------------------------------------------
// Power fault monitor
// Power-state keeper and alarm checker for a power stage.
// ----------------------------------------------------------------------------
// Path from an input transfer to its first result: the input register, then
// the result register of the sequencer.
// Throughput: one item per cycle while the output is not stalled, if the item
// causes one result or none; a check's alarms hold the sequencer until all go out.
// Reset (rst, synchronous): state not connected, deadline zero, registers at
// their defaults, no item held.
module power_fault_monitor #(
  parameter int TEMP_SHIFT = pfm_pkg::TEMP_SHIFT_DEF,
  parameter int TICK_WIDTH = pfm_pkg::TICK_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // now_tick[31:0], pwm_status[37:32], mean_current[53:38], volt_at_peak[69:54],
  // air_temp_raw[85:70], fet_temp_raw[101:86], requested_state[103:102]
  input  logic [pfm_pkg::IN_DATA_W-1:0]  s_tdata,
  // op[0]
  input  logic                           s_tuser,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // msg_code[7:0], arg_a[23:8], arg_b[39:24], msg_long[40], power_state[42:41],
  // power_down[43], keepalive_on[44], change_status[46:45], led_fault_kind[48:47]
  output logic [pfm_pkg::OUT_DATA_W-1:0] m_tdata,
  // kind[0]
  output logic                           m_tuser,
  output logic                           m_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pfm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pfm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pfm_pkg::*;

  cfg_t  cfg;
  item_t in_item;
  logic  in_valid;
  logic  consume;
  logic  job_load;
  logic  load_ok;
  job_t  job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.current_limit      <= 16'sh7FFF;
      cfg.air_temp_limit     <= 9'd511;
      cfg.fet_temp_limit     <= 9'd511;
      cfg.alert_disable_mask <= '0;
      cfg.holdoff_ticks      <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CURRENT_LIMIT: cfg.current_limit      <= cfg_data[15:0];
        REG_AIR_LIMIT:     cfg.air_temp_limit     <= cfg_data[8:0];
        REG_FET_LIMIT:     cfg.fet_temp_limit     <= cfg_data[8:0];
        REG_DISABLE_MASK:  cfg.alert_disable_mask <= cfg_data[13:0];
        REG_HOLDOFF:       cfg.holdoff_ticks      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: takes a new transfer when empty or when the held item moves on.
  assign s_tready = !in_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.op              <= s_tuser;
      in_item.now_tick        <= s_tdata[31:0];
      in_item.pwm_status      <= s_tdata[37:32];
      in_item.mean_current    <= s_tdata[53:38];
      in_item.volt_at_peak    <= s_tdata[69:54];
      in_item.air_temp_raw    <= s_tdata[85:70];
      in_item.fet_temp_raw    <= s_tdata[101:86];
      in_item.requested_state <= s_tdata[103:102];
    end
  end

  pfm_eval #(
    .TEMP_SHIFT(TEMP_SHIFT),
    .TICK_WIDTH(TICK_WIDTH)
  ) u_eval (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_item (in_item),
    .cfg     (cfg),
    .load_ok (load_ok),
    .consume (consume),
    .job_load(job_load),
    .job     (job)
  );

  pfm_emit u_emit (
    .clk     (clk),
    .rst     (rst),
    .job_load(job_load),
    .job_in  (job),
    .load_ok (load_ok),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

endmodule

FILE: hw/rtl/pfm_checker.sv
// ----------------------------------------------------------------------------
// Power fault monitor checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module pfm_checker (
  input logic                           clk,
  input logic                           rst,
  input logic [pfm_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                           m_tuser,
  input logic                           m_tlast,
  input logic                           m_tvalid,
  input logic                           m_tready
);
  import pfm_pkg::*;

  // A stalled result holds its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result changed while stalled");

  // Every alarm leaves the stage off.
  a_alarm_off: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_ALARM |-> m_tdata[42:41] == PM_OFF)
    else $error("alarm with power state other than off");

  // A refused request changes nothing and pulses nothing.
  a_invalid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_REPLY && m_tdata[46:45] == CS_INVALID
      |-> !m_tdata[43] && !m_tdata[44])
    else $error("invalid request produced a pulse");

  // Keepalive comes only from a reply that lands in the on state.
  a_keepalive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[44] |-> m_tuser == KIND_REPLY && m_tdata[42:41] == PM_ON
      && m_tlast)
    else $error("keepalive pulse outside an off to on reply");

endmodule

bind power_fault_monitor pfm_checker u_pfm_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser),
  .m_tlast (m_tlast),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready)
);

FILE: tb/sv/tb_power_fault_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Power fault monitor testbench
// Sends check and power-state request items over the input stream. A local
// predictor keeps its own power state, holdoff deadline and register copies,
// and works out the alarm messages and replies each item should produce. The
// output stream is compared field by field against them, under several
// register settings and with random idle cycles on both stream sides.
// ----------------------------------------------------------------------------
module tb_power_fault_monitor;
  import pfm_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 10;
  localparam int DRAIN_CYCLES   = 16;
  localparam int HOLD_LEN       = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 10;
  localparam int PHASE_ITEMS    = 40;

  // Disable-mask bit positions of the faults.
  localparam logic [5:0][3:0] PWM_MASK_BIT = {4'd13, 4'd8, 4'd7, 4'd6, 4'd5, 4'd4};
  localparam int MASK_BIT_CUR = 9;
  localparam int MASK_BIT_AIR = 10;
  localparam int MASK_BIT_FET = 11;
  localparam logic [5:0][7:0] PWM_MSG =
    {MSG_PWM345, MSG_PWM345, MSG_PWM345, MSG_PWM12, MSG_PWM12, MSG_PWM0};
  localparam logic [5:0][7:0] PWM_ARG = {8'h0C, 8'h0B, 8'h0A, 8'h0B, 8'h0A, 8'h00};
  localparam logic [1:0] REQ_INVALID = 2'd3;
  localparam logic [13:0] MASK_ALL_PWM = 14'h21F0;

  typedef struct packed {
    logic           kind;
    logic [7:0]     code;
    logic [15:0]    arg_a;
    logic [15:0]    arg_b;
    logic           msg_long;
    power_mode_t    state;
    logic           power_down;
    logic           keepalive;
    change_status_t status;
    led_kind_t      led;
    logic           last;
  } monitor_msg_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor state.
  cfg_t         mon_cfg;
  power_mode_t  mon_mode;
  logic [31:0]  mon_deadline;
  monitor_msg_t outgoing_msgs[$];
  logic [31:0]  tick_now;

  int error_count  = 0;
  int idle_pct     = 0;
  int stall_pct    = 0;
  int hold_req     = 0;
  int hold_ack     = 0;
  int hold_left    = 0;
  int quiet_cycles = 0;

  power_fault_monitor u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic monitor_msg_t raise_alarm(input logic [7:0] code,
                                               input logic [15:0] a,
                                               input logic [15:0] b,
                                               input logic lng,
                                               input led_kind_t led);
    monitor_msg_t m;
    m          = '0;
    m.kind     = KIND_ALARM;
    m.code     = code;
    m.arg_a    = a;
    m.arg_b    = b;
    m.msg_long = lng;
    m.led      = led;
    m.status   = CS_ALREADY;
    // Only the first unmasked alarm trips the stage; later ones see it off.
    if (mon_mode == PM_ON) begin
      m.power_down = 1'b1;
      m.status     = CS_CHANGED;
    end
    if (mon_mode != PM_NC) begin
      mon_mode = PM_OFF;
    end else begin
      m.status = CS_INVALID;
    end
    m.state = mon_mode;
    return m;
  endfunction

  function automatic void monitor_step(input item_t it);
    monitor_msg_t batch[$];
    monitor_msg_t m;
    logic         fault;
    logic [8:0]   t_air;
    logic [8:0]   t_fet;
    int           i;
    fault = 1'b0;
    t_air = 9'(it.air_temp_raw >> TEMP_SHIFT_DEF);
    t_fet = 9'(it.fet_temp_raw >> TEMP_SHIFT_DEF);
    if (it.op == OP_CHECK) begin
      if (mon_deadline > it.now_tick || mon_mode != PM_ON) begin
        return;
      end
      for (i = 0; i < 6; i++) begin
        if (!it.pwm_status[i]) begin
          fault = 1'b1;
          if (!mon_cfg.alert_disable_mask[PWM_MASK_BIT[i]]) begin
            batch.push_back(raise_alarm(PWM_MSG[i], {PWM_ARG[i], 8'h00}, 16'h0,
                                        1'b0, LED_OTHER));
          end
        end
      end
      if (it.mean_current >= mon_cfg.current_limit) begin
        fault = 1'b1;
        if (!mon_cfg.alert_disable_mask[MASK_BIT_CUR]) begin
          batch.push_back(raise_alarm(MSG_CURRENT,
                                      it.mean_current[15] ? 16'h0 : it.mean_current,
                                      it.volt_at_peak[15] ? 16'h0 : it.volt_at_peak,
                                      1'b1, LED_OTHER));
        end
      end
      if (t_air >= mon_cfg.air_temp_limit) begin
        fault = 1'b1;
        if (!mon_cfg.alert_disable_mask[MASK_BIT_AIR]) begin
          batch.push_back(raise_alarm(MSG_AIR, {t_air[7:0], 8'h00}, 16'h0, 1'b0, LED_TEMP));
        end
      end
      if (t_fet >= mon_cfg.fet_temp_limit) begin
        fault = 1'b1;
        if (!mon_cfg.alert_disable_mask[MASK_BIT_FET]) begin
          batch.push_back(raise_alarm(MSG_FET, {t_fet[7:0], 8'h00}, 16'h0, 1'b0, LED_TEMP));
        end
      end
      if (fault) begin
        mon_deadline = it.now_tick + mon_cfg.holdoff_ticks;
      end
    end else begin
      m      = '0;
      m.kind = KIND_REPLY;
      m.led  = LED_NONE;
      if (it.requested_state == REQ_INVALID ||
          (mon_mode == PM_NC && it.requested_state == PM_ON)) begin
        m.status = CS_INVALID;
      end else if (it.requested_state == mon_mode) begin
        m.status = CS_ALREADY;
      end else begin
        m.status     = CS_CHANGED;
        m.power_down = (mon_mode == PM_ON);
        m.keepalive  = (mon_mode == PM_OFF && it.requested_state == PM_ON);
        mon_mode     = power_mode_t'(it.requested_state);
      end
      m.state = mon_mode;
      batch.push_back(m);
    end
    if (batch.size() > 0) begin
      batch[batch.size() - 1].last = 1'b1;
    end
    foreach (batch[k]) begin
      outgoing_msgs.push_back(batch[k]);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Item builders
  // --------------------------------------------------------------------------
  function automatic item_t check_item(input logic [5:0] pwm, input logic signed [15:0] cur,
                                       input logic signed [15:0] volt,
                                       input logic [15:0] air, input logic [15:0] fet);
    item_t it;
    it.op              = OP_CHECK;
    it.now_tick        = tick_now;
    it.pwm_status      = pwm;
    it.mean_current    = cur;
    it.volt_at_peak    = volt;
    it.air_temp_raw    = air;
    it.fet_temp_raw    = fet;
    it.requested_state = 2'($urandom_range(0, 3));
    tick_now           = tick_now + 32'd10;
    return it;
  endfunction

  function automatic item_t random_check();
    item_t it;
    int    v;
    if ($urandom_range(0, 19) == 0) begin
      tick_now = $urandom();
    end else begin
      tick_now = tick_now + $urandom_range(0, 40);
    end
    it.op       = OP_CHECK;
    it.now_tick = tick_now;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: it.pwm_status = 6'h3F;
      5, 6, 7:       it.pwm_status = ~(6'd1 << $urandom_range(0, 5));
      default:       it.pwm_status = 6'($urandom());
    endcase
    if ($urandom_range(0, 1) == 0) begin
      it.mean_current = 16'($urandom());
    end else begin
      v = int'(mon_cfg.current_limit) + int'($urandom_range(0, 40)) - 30;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      it.mean_current = v[15:0];
    end
    it.volt_at_peak = 16'($urandom());
    if ($urandom_range(0, 1) == 0) begin
      it.air_temp_raw = 16'($urandom());
      it.fet_temp_raw = 16'($urandom());
    end else begin
      v = (int'(mon_cfg.air_temp_limit) << TEMP_SHIFT_DEF) + int'($urandom_range(0, 600)) - 400;
      it.air_temp_raw = (v < 0) ? 16'h0 : (v > 65535) ? 16'hFFFF : v[15:0];
      v = (int'(mon_cfg.fet_temp_limit) << TEMP_SHIFT_DEF) + int'($urandom_range(0, 600)) - 400;
      it.fet_temp_raw = (v < 0) ? 16'h0 : (v > 65535) ? 16'hFFFF : v[15:0];
    end
    it.requested_state = 2'($urandom_range(0, 3));
    return it;
  endfunction

  function automatic item_t request_item(input logic [1:0] req);
    item_t it;
    it                 = random_check();
    it.op              = OP_REQUEST;
    it.requested_state = req;
    return it;
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.current_limit      = 16'($urandom_range(0, 6000) - 1000);
    c.air_temp_limit     = 9'($urandom_range(100, 500));
    c.fet_temp_limit     = 9'($urandom_range(100, 500));
    c.alert_disable_mask = 14'($urandom() & $urandom());
    c.holdoff_ticks      = $urandom_range(0, 60);
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Stream and register drivers
  // --------------------------------------------------------------------------
  task automatic send_item(input item_t it);
    s_tdata  <= {it.requested_state, it.fet_temp_raw, it.air_temp_raw, it.volt_at_peak,
                 it.mean_current, it.pwm_status, it.now_tick};
    s_tuser  <= it.op;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    monitor_step(it);
    if ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
  endtask

  // Items that produce nothing may still be in flight when the last message
  // arrives, so give the block a few more cycles before touching registers.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (outgoing_msgs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_config(input cfg_t c);
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic [31:0]           junk;
    int                    k;
    for (k = 0; k < 6; k++) begin
      junk = $urandom();
      case (k)
        0: begin idx = REG_CURRENT_LIMIT; val = {junk[31:16], c.current_limit}; end
        1: begin idx = REG_AIR_LIMIT;     val = {junk[31:9], c.air_temp_limit}; end
        2: begin idx = REG_FET_LIMIT;     val = {junk[31:9], c.fet_temp_limit}; end
        3: begin idx = REG_DISABLE_MASK;  val = {junk[31:14], c.alert_disable_mask}; end
        4: begin idx = REG_HOLDOFF;       val = c.holdoff_ticks; end
        // An index past the register file must be ignored.
        default: begin
          idx = CFG_IDX_W'(REG_HOLDOFF + 1 + $urandom_range(0, 2));
          val = junk;
        end
      endcase
      cfg_index <= idx;
      cfg_data  <= val;
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (idx)
        REG_CURRENT_LIMIT: mon_cfg.current_limit      = val[15:0];
        REG_AIR_LIMIT:     mon_cfg.air_temp_limit     = val[8:0];
        REG_FET_LIMIT:     mon_cfg.fet_temp_limit     = val[8:0];
        REG_DISABLE_MASK:  mon_cfg.alert_disable_mask = val[13:0];
        REG_HOLDOFF:       mon_cfg.holdoff_ticks      = val;
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Receiver side, result checking and watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("%s", msg);
    end
  endtask

  always @(posedge clk) begin : check_results
    monitor_msg_t got;
    monitor_msg_t want;
    string        bad;
    if (!rst && m_tvalid && m_tready) begin
      got.kind       = m_tuser;
      got.code       = m_tdata[7:0];
      got.arg_a      = m_tdata[23:8];
      got.arg_b      = m_tdata[39:24];
      got.msg_long   = m_tdata[40];
      got.state      = power_mode_t'(m_tdata[42:41]);
      got.power_down = m_tdata[43];
      got.keepalive  = m_tdata[44];
      got.status     = change_status_t'(m_tdata[46:45]);
      got.led        = led_kind_t'(m_tdata[48:47]);
      got.last       = m_tlast;
      if (outgoing_msgs.size() == 0) begin
        note_error($sformatf("%0t: unexpected result %h", $realtime, got));
      end else begin
        want = outgoing_msgs.pop_front();
        bad  = "";
        if (got.kind !== want.kind)             bad = {bad, " kind"};
        if (got.code !== want.code)             bad = {bad, " msg_code"};
        if (got.arg_a !== want.arg_a)           bad = {bad, " arg_a"};
        if (got.arg_b !== want.arg_b)           bad = {bad, " arg_b"};
        if (got.msg_long !== want.msg_long)     bad = {bad, " msg_long"};
        if (got.state !== want.state)           bad = {bad, " power_state"};
        if (got.power_down !== want.power_down) bad = {bad, " power_down"};
        if (got.keepalive !== want.keepalive)   bad = {bad, " keepalive_on"};
        if (got.status !== want.status)         bad = {bad, " change_status"};
        if (got.led !== want.led)               bad = {bad, " led_fault_kind"};
        if (got.last !== want.last)             bad = {bad, " last"};
        if (bad != "") begin
          note_error($sformatf("%0t: mismatch in%s: expected %h, got %h",
                               $realtime, bad, want, got));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_power_requests();
    // Not connected yet, so even a check full of faults is ignored.
    send_item(check_item(6'h00, 16'sh7FFF, 16'sh7FFF, 16'hFFFF, 16'hFFFF));
    send_item(request_item(PM_ON));
    send_item(request_item(REQ_INVALID));
    send_item(request_item(PM_NC));
    send_item(request_item(PM_OFF));
    send_item(request_item(PM_OFF));
    send_item(request_item(PM_NC));
    send_item(request_item(PM_OFF));
    send_item(request_item(PM_ON));
    send_item(request_item(PM_ON));
    send_item(request_item(PM_OFF));
    send_item(request_item(PM_ON));
    send_item(request_item(PM_NC));
    send_item(request_item(PM_OFF));
    send_item(request_item(PM_ON));
  endtask

  task automatic test_fault_messages();
    send_item(check_item(6'h3F, 16'sh8000, 16'sh0000, 16'h0000, 16'h0000));
    // Every fault at once under the reset limits: nine messages, one trip.
    send_item(check_item(6'h00, 16'sh7FFF, 16'sh8000, 16'hFFFF, 16'hFFFF));
    send_item(check_item(6'h00, 16'sh7FFF, 16'sh7FFF, 16'hFFFF, 16'hFFFF));
    send_item(request_item(PM_ON));
    send_item(check_item(6'h3F, 16'sh7FFF, 16'sh7FFF, 16'h0000, 16'h0000));
  endtask

  task automatic test_holdoff_and_mask();
    wait_drained();
    load_config('{16'sh8000, 9'd300, 9'd0, MASK_ALL_PWM, 32'd100});
    send_item(request_item(PM_ON));
    // Masked PWM faults still rearm the holdoff; the temperature byte is truncated.
    tick_now = 32'd5000;
    send_item(check_item(6'h00, -16'sd5, 16'sd1234, 16'd38400, 16'h007F));
    send_item(request_item(PM_ON));
    tick_now = 32'd5099;
    send_item(check_item(6'h00, 16'sh7FFF, 16'sh7FFF, 16'hFFFF, 16'hFFFF));
    send_item(check_item(6'h15, 16'sh7FFF, 16'sh7FFF, 16'hFFFF, 16'hFFFF));
  endtask

  task automatic test_random_traffic(input int send_idle, input int recv_stall,
                                     input cfg_t c);
    int sent;
    int k;
    wait_drained();
    load_config(c);
    idle_pct  = send_idle;
    stall_pct = recv_stall;
    sent      = 0;
    while (sent < PHASE_ITEMS) begin
      if ($urandom_range(0, 9) < 6) begin
        // Power up, then let a few checks run against the new state.
        send_item(request_item(PM_ON));
        sent++;
        for (k = $urandom_range(1, 3); k > 0; k--) begin
          send_item(random_check());
          sent++;
        end
      end else begin
        if ($urandom_range(0, 1) == 0) begin
          send_item(request_item(2'($urandom_range(0, 3))));
        end else begin
          send_item(random_check());
        end
        sent++;
      end
    end
  endtask

  task automatic test_backpressure();
    int k;
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = hold_req + 1;
    for (k = 0; k < 20; k++) begin
      send_item((k % 4 == 0) ? request_item(PM_ON) : random_check());
    end
    wait_drained();
    for (k = 0; k < 10; k++) begin
      send_item((k % 3 == 0) ? request_item(PM_ON) : random_check());
    end
  endtask

  initial begin
    mon_cfg      = '{16'sh7FFF, 9'd511, 9'd511, 14'd0, 32'd0};
    mon_mode     = PM_NC;
    mon_deadline = 32'd0;
    tick_now     = 32'd1000;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_power_requests();
    test_fault_messages();
    test_holdoff_and_mask();
    test_random_traffic(0, 0, '{16'sh8000, 9'd0, 9'd0, 14'd0, 32'd0});
    test_backpressure();
    test_random_traffic(61, 0, '{16'sh7FFF, 9'd511, 9'd511, 14'h3FFF, 32'hFFFF_FFFF});
    test_random_traffic(0, 61, random_cfg());
    test_random_traffic(9, 9, random_cfg());
    wait_drained();

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
